### design/rrq_pkg.sv
// Package for the two-level round-robin run queue unit.
// Holds sizes, entry type, operation and status codes, sequencer states.
// No dependencies.
package rrq_pkg;

  // Sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int PID_W       = 22;
  localparam int KEY_W       = 22;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int ENTRY_W     = PID_W + ID_BITS;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // One queue slot
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [ID_BITS-1:0] id;
  } entry_t;

  // Operation codes
  typedef enum logic [2:0] {
    K_INSERT    = 3'd0,
    K_POP_NEXT  = 3'd1,
    K_ROTATE    = 3'd2,
    K_ERASE_ID  = 3'd3,
    K_ERASE_PID = 3'd4,
    K_FIND_ID   = 3'd5,
    K_FIND_PID  = 3'd6,
    K_MOVE_ID   = 3'd7
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HEAD,
    S_ROT_RD,
    S_ROT_DONE,
    S_SCAN,
    S_FOUND,
    S_SHIFT
  } state_e;

  // Circular slot address: head plus an offset, wrapped at the depth
  function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] head,
                                                  logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(off);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

### design/rrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrq_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rrq_cmp.sv
// Shared key compare unit: matches a stored entry against the search key.
// Depends on rrq_pkg.
module rrq_cmp (
  input  logic                      by_id_i,
  input  logic [rrq_pkg::KEY_W-1:0] key_i,
  input  rrq_pkg::entry_t           entry_i,
  output logic                      match_o
);

  logic id_hit;
  logic pid_hit;

  // Id match uses the whole stored id; key bits above it must be zero
  assign id_hit  = (key_i == rrq_pkg::KEY_W'(entry_i.id));
  assign pid_hit = (key_i == entry_i.pid);
  assign match_o = by_id_i ? id_hit : pid_hit;

endmodule

### design/two_level_round_robin_run_queue_unit.sv
// Top level of the two-level round-robin run queue unit.
// Depends on rrq_pkg, rrq_ram, rrq_cmp.
//
// Command port: a transaction is taken when start is high and busy is low;
// exactly one result follows, shown for one cycle with valid_o high, and
// the receiver cannot stall it. Each level is a circular buffer in its own
// RAM (one read, one write port) with a head pointer and a count. All work
// goes through the RAM read port, one slot per cycle, with a shared key
// comparator. A search compares one slot per cycle, high level first, then
// low (move looks only in its source level). Erase and move then close the
// gap, shifting each entry behind the match up by one slot. busy is high
// from accept until the result strobe; a new command may be given in the
// strobe cycle.
module two_level_round_robin_run_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  kind_i,
  input  logic                        level_i,
  input  logic [rrq_pkg::KEY_W-1:0]   key_i,
  output logic                        valid_o,
  output logic [1:0]                  status_o,
  output logic [rrq_pkg::PID_W-1:0]   entry_pid_o,
  output logic [rrq_pkg::ID_BITS-1:0] entry_id_o,
  output logic                        entry_level_o,
  output logic                        all_empty_o
);

  localparam int AW = rrq_pkg::ADDR_W;
  localparam int CW = rrq_pkg::CNT_W;

  // Control state
  rrq_pkg::state_e                      state_q, state_d;
  logic [1:0][CW-1:0]                   cnt_q, cnt_d;
  logic [1:0][AW-1:0]                   head_q, head_d;
  logic [rrq_pkg::ID_BITS-1:0]          serial_q, serial_d;
  logic                                 pend_q, pend_d;
  logic                                 valid_q, valid_d;

  // Command and walk payload
  rrq_pkg::kind_e                       kind_q, kind_d;
  logic                                 level_q, level_d;
  logic [rrq_pkg::KEY_W-1:0]            key_q, key_d;
  logic                                 lv_q, lv_d;
  logic [CW-1:0]                        off_q, off_d;
  logic [CW-1:0]                        poff_q, poff_d;

  // Result registers
  rrq_pkg::status_e                     res_status_q, res_status_d;
  logic [rrq_pkg::PID_W-1:0]            res_pid_q, res_pid_d;
  logic [rrq_pkg::ID_BITS-1:0]          res_id_q, res_id_d;
  logic                                 res_lvl_q, res_lvl_d;

  // RAM ports, one per level
  logic [1:0]                           ram_we;
  logic [1:0][AW-1:0]                   ram_waddr;
  rrq_pkg::entry_t [1:0]                ram_wdata;
  logic [1:0][AW-1:0]                   ram_raddr;
  rrq_pkg::entry_t [1:0]                ram_rdata;

  // Shared flags
  rrq_pkg::entry_t                      cur_rd;
  logic                                 accept;
  logic                                 none;
  logic                                 by_id;
  logic                                 match;
  logic                                 hit;
  logic                                 more;
  logic                                 dst_full;
  logic                                 fail;
  rrq_pkg::status_e                     fail_status;

  // Level memories
  for (genvar g = 0; g < 2; g++) begin : g_level
    rrq_ram #(
      .WIDTH(rrq_pkg::ENTRY_W),
      .DEPTH(rrq_pkg::QUEUE_DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[g]),
      .waddr_i(ram_waddr[g]),
      .wdata_i(ram_wdata[g]),
      .raddr_i(ram_raddr[g]),
      .rdata_o(ram_rdata[g])
    );
  end

  // Key comparator
  rrq_cmp u_cmp (
    .by_id_i(by_id),
    .key_i  (key_q),
    .entry_i(cur_rd),
    .match_o(match)
  );

  assign cur_rd   = ram_rdata[lv_q];
  assign busy     = (state_q != rrq_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign none     = (cnt_q[0] == '0) && (cnt_q[1] == '0);
  assign by_id    = (kind_q == rrq_pkg::K_ERASE_ID) || (kind_q == rrq_pkg::K_FIND_ID) ||
                    (kind_q == rrq_pkg::K_MOVE_ID);
  assign hit      = pend_q && match;
  assign more     = (off_q < cnt_q[lv_q]);
  assign dst_full = (cnt_q[level_q] == rrq_pkg::DEPTH_C);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrq_pkg::S_IDLE: begin
        if (accept) state_d = rrq_pkg::S_EXEC;
      end
      rrq_pkg::S_EXEC: begin
        unique case (kind_q) inside
          rrq_pkg::K_INSERT: state_d = rrq_pkg::S_IDLE;
          rrq_pkg::K_POP_NEXT, rrq_pkg::K_ROTATE: begin
            state_d = none ? rrq_pkg::S_IDLE : rrq_pkg::S_HEAD;
          end
          default: begin
            state_d = none ? rrq_pkg::S_IDLE : rrq_pkg::S_SCAN;
          end
        endcase
      end
      rrq_pkg::S_HEAD: begin
        state_d = (kind_q == rrq_pkg::K_ROTATE) ? rrq_pkg::S_ROT_RD : rrq_pkg::S_IDLE;
      end
      rrq_pkg::S_ROT_RD:   state_d = rrq_pkg::S_ROT_DONE;
      rrq_pkg::S_ROT_DONE: state_d = rrq_pkg::S_IDLE;
      rrq_pkg::S_SCAN: begin
        if (hit) begin
          state_d = rrq_pkg::S_FOUND;
        end else if (!more && !(lv_q && kind_q != rrq_pkg::K_MOVE_ID)) begin
          state_d = rrq_pkg::S_IDLE;
        end
      end
      rrq_pkg::S_FOUND: begin
        if (kind_q == rrq_pkg::K_FIND_ID || kind_q == rrq_pkg::K_FIND_PID ||
            (kind_q == rrq_pkg::K_MOVE_ID && dst_full)) begin
          state_d = rrq_pkg::S_IDLE;
        end else begin
          state_d = rrq_pkg::S_SHIFT;
        end
      end
      rrq_pkg::S_SHIFT: begin
        if (!more) state_d = rrq_pkg::S_IDLE;
      end
      default: state_d = rrq_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM control and results
  always_comb begin
    cnt_d        = cnt_q;
    head_d       = head_q;
    serial_d     = serial_q;
    pend_d       = pend_q;
    valid_d      = 1'b0;
    kind_d       = kind_q;
    level_d      = level_q;
    key_d        = key_q;
    lv_d         = lv_q;
    off_d        = off_q;
    poff_d       = poff_q;
    res_status_d = res_status_q;
    res_pid_d    = res_pid_q;
    res_id_d     = res_id_q;
    res_lvl_d    = res_lvl_q;
    ram_we       = '0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    fail         = 1'b0;
    fail_status  = rrq_pkg::ST_OK;

    unique case (state_q)
      rrq_pkg::S_IDLE: begin
        if (accept) begin
          kind_d  = rrq_pkg::kind_e'(kind_i);
          level_d = level_i;
          key_d   = key_i;
        end
      end

      rrq_pkg::S_EXEC: begin
        unique case (kind_q) inside
          rrq_pkg::K_INSERT: begin
            if (dst_full) begin
              fail        = 1'b1;
              fail_status = rrq_pkg::ST_FULL;
            end else begin
              ram_we[level_q]    = 1'b1;
              ram_waddr[level_q] = rrq_pkg::wrap_add(head_q[level_q], cnt_q[level_q]);
              ram_wdata[level_q] = '{pid: key_q, id: serial_q};
              cnt_d[level_q]     = cnt_q[level_q] + CW'(1);
              serial_d           = serial_q + rrq_pkg::ID_BITS'(1);
              res_status_d       = rrq_pkg::ST_OK;
              res_pid_d          = key_q;
              res_id_d           = serial_q;
              res_lvl_d          = level_q;
              valid_d            = 1'b1;
            end
          end
          rrq_pkg::K_POP_NEXT, rrq_pkg::K_ROTATE: begin
            if (none) begin
              fail        = 1'b1;
              fail_status = rrq_pkg::ST_EMPTY;
            end else begin
              // Serve high when it holds anything
              lv_d = (cnt_q[1] != '0);
              ram_raddr[lv_d] = head_q[lv_d];
            end
          end
          default: begin
            if (none) begin
              fail        = 1'b1;
              fail_status = rrq_pkg::ST_EMPTY;
            end else begin
              lv_d   = (kind_q == rrq_pkg::K_MOVE_ID) ? !level_q : 1'b1;
              off_d  = '0;
              pend_d = 1'b0;
            end
          end
        endcase
      end

      // Head entry is on the read data
      rrq_pkg::S_HEAD: begin
        head_d[lv_q] = rrq_pkg::wrap_add(head_q[lv_q], CW'(1));
        if (kind_q == rrq_pkg::K_ROTATE) begin
          ram_we[lv_q]    = 1'b1;
          ram_waddr[lv_q] = rrq_pkg::wrap_add(head_q[lv_q], cnt_q[lv_q]);
          ram_wdata[lv_q] = cur_rd;
        end else begin
          cnt_d[lv_q]  = cnt_q[lv_q] - CW'(1);
          res_status_d = rrq_pkg::ST_OK;
          res_pid_d    = cur_rd.pid;
          res_id_d     = cur_rd.id;
          res_lvl_d    = lv_q;
          valid_d      = 1'b1;
        end
      end

      // Read the new head after the rotate write has landed
      rrq_pkg::S_ROT_RD: begin
        ram_raddr[lv_q] = head_q[lv_q];
      end

      rrq_pkg::S_ROT_DONE: begin
        res_status_d = rrq_pkg::ST_OK;
        res_pid_d    = cur_rd.pid;
        res_id_d     = cur_rd.id;
        res_lvl_d    = lv_q;
        valid_d      = 1'b1;
      end

      // Walk one slot per cycle, compare the slot read in the previous cycle
      rrq_pkg::S_SCAN: begin
        if (hit) begin
          res_pid_d = cur_rd.pid;
          res_id_d  = cur_rd.id;
          res_lvl_d = lv_q;
          pend_d    = 1'b0;
        end else if (more) begin
          ram_raddr[lv_q] = rrq_pkg::wrap_add(head_q[lv_q], off_q);
          poff_d          = off_q;
          off_d           = off_q + CW'(1);
          pend_d          = 1'b1;
        end else if (lv_q && kind_q != rrq_pkg::K_MOVE_ID) begin
          lv_d   = 1'b0;
          off_d  = '0;
          pend_d = 1'b0;
        end else begin
          fail        = 1'b1;
          fail_status = rrq_pkg::ST_NOT_FOUND;
        end
      end

      rrq_pkg::S_FOUND: begin
        res_status_d = rrq_pkg::ST_OK;
        off_d        = poff_q + CW'(1);
        pend_d       = 1'b0;
        unique case (kind_q) inside
          rrq_pkg::K_FIND_ID, rrq_pkg::K_FIND_PID: begin
            valid_d = 1'b1;
          end
          rrq_pkg::K_MOVE_ID: begin
            if (dst_full) begin
              fail        = 1'b1;
              fail_status = rrq_pkg::ST_FULL;
            end else begin
              ram_we[level_q]    = 1'b1;
              ram_waddr[level_q] = rrq_pkg::wrap_add(head_q[level_q], cnt_q[level_q]);
              ram_wdata[level_q] = '{pid: res_pid_q, id: res_id_q};
              cnt_d[level_q]     = cnt_q[level_q] + CW'(1);
            end
          end
          default: ;
        endcase
      end

      // Close the gap: slot j+1 moves to slot j, read and write overlapped
      rrq_pkg::S_SHIFT: begin
        if (pend_q) begin
          ram_we[lv_q]    = 1'b1;
          ram_waddr[lv_q] = rrq_pkg::wrap_add(head_q[lv_q], poff_q - CW'(1));
          ram_wdata[lv_q] = cur_rd;
        end
        if (more) begin
          ram_raddr[lv_q] = rrq_pkg::wrap_add(head_q[lv_q], off_q);
          poff_d          = off_q;
          off_d           = off_q + CW'(1);
          pend_d          = 1'b1;
        end else begin
          pend_d      = 1'b0;
          cnt_d[lv_q] = cnt_q[lv_q] - CW'(1);
          valid_d     = 1'b1;
        end
      end

      default: ;
    endcase

    // Failed command: status only, fields zero
    if (fail) begin
      res_status_d = fail_status;
      res_pid_d    = '0;
      res_id_d     = '0;
      res_lvl_d    = 1'b0;
      valid_d      = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rrq_pkg::S_IDLE;
      cnt_q    <= '0;
      head_q   <= '0;
      serial_q <= '0;
      pend_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      serial_q <= serial_d;
      pend_q   <= pend_d;
      valid_q  <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    level_q      <= level_d;
    key_q        <= key_d;
    lv_q         <= lv_d;
    off_q        <= off_d;
    poff_q       <= poff_d;
    res_status_q <= res_status_d;
    res_pid_q    <= res_pid_d;
    res_id_q     <= res_id_d;
    res_lvl_q    <= res_lvl_d;
  end

  // Outputs
  assign valid_o       = valid_q;
  assign status_o      = res_status_q;
  assign entry_pid_o   = res_pid_q;
  assign entry_id_o    = res_id_q;
  assign entry_level_o = res_lvl_q;
  assign all_empty_o   = none;

  // Checks
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while a command is still running");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != rrq_pkg::ST_OK) |->
      (entry_pid_o == '0 && entry_id_o == '0 && !entry_level_o))
    else $error("failed command returned nonzero entry fields");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= rrq_pkg::DEPTH_C) && (cnt_q[1] <= rrq_pkg::DEPTH_C))
    else $error("queue count above depth");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

### bench/tb_two_level_round_robin_run_queue_unit.sv
// Testbench for the two-level round-robin run queue unit: a directed command
// table, then random command mixes that fill, churn and drain both levels.
// Depends on rrq_pkg and two_level_round_robin_run_queue_unit.
module tb_two_level_round_robin_run_queue_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1600;
  localparam int BLOCK_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 3 * rrq_pkg::QUEUE_DEPTH + 8;
  localparam int MAX_PRINTS   = 200;

  // Expected result of one command
  typedef struct packed {
    rrq_pkg::status_e                 status;
    logic [rrq_pkg::PID_W-1:0]        pid;
    logic [rrq_pkg::ID_BITS-1:0]      id;
    logic                             lvl;
    logic                             all_empty;
  } outcome_t;

  // One command; typed rows carry their own expected outcome
  typedef struct packed {
    rrq_pkg::kind_e                   kind;
    logic                             level;
    logic [rrq_pkg::KEY_W-1:0]        key;
    logic                             typed;
    outcome_t                         res;
  } cmd_t;

  // Model slot: both levels share one list, ordered within each level
  typedef struct packed {
    logic [rrq_pkg::PID_W-1:0]        pid;
    logic [rrq_pkg::ID_BITS-1:0]      id;
    logic                             lvl;
  } slot_t;

  typedef enum {MATCH_HEAD, MATCH_ID, MATCH_PID} match_e;
  typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_e;

  // Directed commands
  localparam cmd_t DIRECTED_CMDS [24] = '{
    '{rrq_pkg::K_POP_NEXT, 1'b0, 22'd0, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_ROTATE, 1'b1, 22'd0, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_ERASE_ID, 1'b0, 22'd0, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_ERASE_PID, 1'b1, 22'h3FFFFF, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_FIND_ID, 1'b0, 22'd0, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_FIND_PID, 1'b0, 22'd0, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_MOVE_ID, 1'b1, 22'd0, 1'b1,
      '{rrq_pkg::ST_EMPTY, 22'd0, 16'd0, 1'b0, 1'b1}},
    '{rrq_pkg::K_INSERT, 1'b0, 22'h3FFFFF, 1'b1,
      '{rrq_pkg::ST_OK, 22'h3FFFFF, 16'd0, 1'b0, 1'b0}},
    '{rrq_pkg::K_INSERT, 1'b1, 22'd0, 1'b1,
      '{rrq_pkg::ST_OK, 22'd0, 16'd1, 1'b1, 1'b0}},
    '{rrq_pkg::K_FIND_ID, 1'b0, 22'h3FFFFF, 1'b1,
      '{rrq_pkg::ST_NOT_FOUND, 22'd0, 16'd0, 1'b0, 1'b0}},
    // bits above the id width never match, even with id 0 present
    '{rrq_pkg::K_FIND_ID, 1'b0, 22'h010000, 1'b1,
      '{rrq_pkg::ST_NOT_FOUND, 22'd0, 16'd0, 1'b0, 1'b0}},
    '{rrq_pkg::K_FIND_PID, 1'b1, 22'h3FFFFF, 1'b1,
      '{rrq_pkg::ST_OK, 22'h3FFFFF, 16'd0, 1'b0, 1'b0}},
    '{rrq_pkg::K_INSERT,    1'b1, 22'h155555,  1'b0, '0},
    '{rrq_pkg::K_INSERT,    1'b1, 22'h2AAAAA,  1'b0, '0},
    // erase the second entry of the high queue
    '{rrq_pkg::K_ERASE_ID,  1'b0, 22'd2,       1'b0, '0},
    '{rrq_pkg::K_INSERT,    1'b0, 22'd0,       1'b0, '0},
    // duplicate pid: high queue wins
    '{rrq_pkg::K_FIND_PID,  1'b0, 22'd0,       1'b0, '0},
    '{rrq_pkg::K_MOVE_ID,   1'b1, 22'd4,       1'b0, '0},
    // already in the destination level
    '{rrq_pkg::K_MOVE_ID,   1'b1, 22'd4,       1'b0, '0},
    '{rrq_pkg::K_MOVE_ID,   1'b0, 22'd1,       1'b0, '0},
    '{rrq_pkg::K_ROTATE,    1'b0, 22'd0,       1'b0, '0},
    '{rrq_pkg::K_POP_NEXT,  1'b1, 22'd0,       1'b0, '0},
    '{rrq_pkg::K_ERASE_PID, 1'b0, 22'h2AAAAA,  1'b0, '0},
    '{rrq_pkg::K_ROTATE,    1'b1, 22'h3FFFFF,  1'b0, '0}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [2:0]                        kind_i;
  logic                              level_i;
  logic [rrq_pkg::KEY_W-1:0]         key_i;
  logic                              valid_o;
  logic [1:0]                        status_o;
  logic [rrq_pkg::PID_W-1:0]         entry_pid_o;
  logic [rrq_pkg::ID_BITS-1:0]       entry_id_o;
  logic                              entry_level_o;
  logic                              all_empty_o;

  slot_t                             run_q [$];
  int                                lvl_count [2];
  logic [rrq_pkg::ID_BITS-1:0]       next_serial;
  outcome_t                          pending_results [$];
  int                                err_count;
  int                                sender_idle_pct;

  two_level_round_robin_run_queue_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .level_i       (level_i),
    .key_i         (key_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .entry_pid_o   (entry_pid_o),
    .entry_id_o    (entry_id_o),
    .entry_level_o (entry_level_o),
    .all_empty_o   (all_empty_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // First slot of a level that matches, or -1
  function automatic int locate(logic lv, match_e how, logic [rrq_pkg::KEY_W-1:0] key);
    for (int i = 0; i < run_q.size(); i++) begin
      if (run_q[i].lvl == lv) begin
        if (how == MATCH_HEAD) return i;
        if (how == MATCH_ID && rrq_pkg::KEY_W'(run_q[i].id) == key) return i;
        if (how == MATCH_PID && run_q[i].pid == key) return i;
      end
    end
    return -1;
  endfunction

  // Queue behavior: applies one command and returns its outcome
  function automatic outcome_t run_queue_step(rrq_pkg::kind_e kind, logic level,
                                              logic [rrq_pkg::KEY_W-1:0] key);
    outcome_t r;
    slot_t    s;
    logic     none;
    logic     lv;
    int       idx;
    match_e   how;
    r = '0;
    r.status = rrq_pkg::ST_OK;
    none = (lvl_count[0] == 0 && lvl_count[1] == 0);
    case (kind) inside
      rrq_pkg::K_INSERT: begin
        if (lvl_count[level] >= rrq_pkg::QUEUE_DEPTH) begin
          r.status = rrq_pkg::ST_FULL;
        end else begin
          s.pid = key;
          s.id  = next_serial;
          s.lvl = level;
          run_q.push_back(s);
          lvl_count[level]++;
          next_serial++;
          r.pid = s.pid;
          r.id  = s.id;
          r.lvl = level;
        end
      end
      rrq_pkg::K_POP_NEXT, rrq_pkg::K_ROTATE: begin
        if (none) begin
          r.status = rrq_pkg::ST_EMPTY;
        end else begin
          lv  = (lvl_count[1] != 0);
          idx = locate(lv, MATCH_HEAD, '0);
          s   = run_q[idx];
          run_q.delete(idx);
          if (kind == rrq_pkg::K_POP_NEXT) begin
            lvl_count[lv]--;
          end else begin
            run_q.push_back(s);
            s = run_q[locate(lv, MATCH_HEAD, '0)];
          end
          r.pid = s.pid;
          r.id  = s.id;
          r.lvl = lv;
        end
      end
      rrq_pkg::K_MOVE_ID: begin
        idx = locate(~level, MATCH_ID, key);
        if (none) begin
          r.status = rrq_pkg::ST_EMPTY;
        end else if (idx < 0) begin
          r.status = rrq_pkg::ST_NOT_FOUND;
        end else if (lvl_count[level] >= rrq_pkg::QUEUE_DEPTH) begin
          r.status = rrq_pkg::ST_FULL;
        end else begin
          s = run_q[idx];
          run_q.delete(idx);
          r.pid = s.pid;
          r.id  = s.id;
          r.lvl = s.lvl;
          lvl_count[s.lvl]--;
          lvl_count[level]++;
          s.lvl = level;
          run_q.push_back(s);
        end
      end
      default: begin
        // erase and find: high level first, then low
        how = (kind == rrq_pkg::K_ERASE_ID || kind == rrq_pkg::K_FIND_ID) ?
              MATCH_ID : MATCH_PID;
        lv  = 1'b1;
        idx = locate(lv, how, key);
        if (idx < 0) begin
          lv  = 1'b0;
          idx = locate(lv, how, key);
        end
        if (none) begin
          r.status = rrq_pkg::ST_EMPTY;
        end else if (idx < 0) begin
          r.status = rrq_pkg::ST_NOT_FOUND;
        end else begin
          r.pid = run_q[idx].pid;
          r.id  = run_q[idx].id;
          r.lvl = lv;
          if (kind == rrq_pkg::K_ERASE_ID || kind == rrq_pkg::K_ERASE_PID) begin
            run_q.delete(idx);
            lvl_count[lv]--;
          end
        end
      end
    endcase
    r.all_empty = (lvl_count[0] == 0 && lvl_count[1] == 0);
    return r;
  endfunction

  // Pids: small pool for duplicates, live pids, and the full range
  function automatic logic [rrq_pkg::KEY_W-1:0] pick_pid();
    case ($urandom_range(3))
      0: return rrq_pkg::KEY_W'($urandom_range(7));
      1: begin
        if (run_q.size() != 0) return run_q[$urandom_range(run_q.size() - 1)].pid;
        return rrq_pkg::KEY_W'($urandom);
      end
      default: return rrq_pkg::KEY_W'($urandom);
    endcase
  endfunction

  // Ids: mostly live ones, then recent, random and over-wide keys
  function automatic logic [rrq_pkg::KEY_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 65 && run_q.size() != 0) begin
      return rrq_pkg::KEY_W'(run_q[$urandom_range(run_q.size() - 1)].id);
    end
    if (r < 80) begin
      return rrq_pkg::KEY_W'(rrq_pkg::ID_BITS'(next_serial - $urandom_range(20)));
    end
    if (r < 92) return rrq_pkg::KEY_W'(rrq_pkg::ID_BITS'($urandom));
    return rrq_pkg::KEY_W'($urandom);
  endfunction

  // Random command, shaped by the current mix
  function automatic cmd_t random_cmd(mix_e mix, logic fav_level);
    cmd_t  c;
    slot_t s;
    int    r;
    int    ins_pct;
    c = '0;
    ins_pct = (mix == MIX_FILL) ? 55 : (mix == MIX_EVEN) ? 25 : 10;
    r = $urandom_range(99);
    c.level = 1'($urandom_range(1));
    c.key   = rrq_pkg::KEY_W'($urandom);
    if (r < ins_pct) begin
      c.kind = rrq_pkg::K_INSERT;
    end else if (mix == MIX_DRAIN && r < 45) begin
      c.kind = ($urandom_range(3) == 0) ? rrq_pkg::K_ROTATE : rrq_pkg::K_POP_NEXT;
    end else begin
      c.kind = rrq_pkg::kind_e'($urandom_range(1, 7));
    end
    case (c.kind) inside
      rrq_pkg::K_INSERT: begin
        if (mix == MIX_FILL && $urandom_range(9) < 8) c.level = fav_level;
        c.key = pick_pid();
      end
      rrq_pkg::K_ERASE_ID, rrq_pkg::K_FIND_ID: c.key = pick_id();
      rrq_pkg::K_ERASE_PID, rrq_pkg::K_FIND_PID: c.key = pick_pid();
      rrq_pkg::K_MOVE_ID: begin
        if (run_q.size() != 0 && $urandom_range(9) < 7) begin
          s = run_q[$urandom_range(run_q.size() - 1)];
          c.key   = rrq_pkg::KEY_W'(s.id);
          c.level = ($urandom_range(9) < 8) ? ~s.lvl : s.lvl;
        end else begin
          c.key = pick_id();
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // Drive one transaction and record what it should return
  task automatic send_cmd(cmd_t c);
    outcome_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= c.kind;
    level_i <= c.level;
    key_i   <= c.key;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    predicted = run_queue_step(c.kind, c.level, c.key);
    pending_results.push_back(c.typed ? c.res : predicted);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display("%0t: %s got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  // Result checking
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni === 1'b1 && valid_o !== 1'b0) begin
      if (valid_o !== 1'b1 || pending_results.size() == 0) begin
        report_mismatch("result strobe with nothing pending", 32'(valid_o), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", 32'(status_o), 32'(want.status));
        if (entry_pid_o !== want.pid) report_mismatch("entry_pid", 32'(entry_pid_o), 32'(want.pid));
        if (entry_id_o !== want.id) report_mismatch("entry_id", 32'(entry_id_o), 32'(want.id));
        if (entry_level_o !== want.lvl) begin
          report_mismatch("entry_level", 32'(entry_level_o), 32'(want.lvl));
        end
        if (all_empty_o !== want.all_empty) begin
          report_mismatch("all_empty", 32'(all_empty_o), 32'(want.all_empty));
        end
      end
    end
  end

  // Stimulus
  initial begin
    mix_e mix;
    logic fav_level;
    start           = 1'b0;
    kind_i          = rrq_pkg::K_INSERT;
    level_i         = 1'b0;
    key_i           = '0;
    rst_ni          = 1'b0;
    next_serial     = '0;
    lvl_count[0]    = 0;
    lvl_count[1]    = 0;
    err_count       = 0;
    sender_idle_pct = 34;
    mix             = MIX_FILL;
    fav_level       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_CMDS[i]) send_cmd(DIRECTED_CMDS[i]);

    // random part in three idle regimes, mixes changing every block
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) sender_idle_pct = 61;
      if (n == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      if (n % BLOCK_ITEMS == 0) begin
        mix       = mix_e'($urandom_range(2));
        fav_level = 1'($urandom_range(1));
      end
      send_cmd(random_cmd(mix, fav_level));
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
